// ===== sv/go_to_point_heading_controller_core_assert.svh =====
// Assertion macros shared by the go-to-point controller RTL.
// Needs i_clk and i_rst_n in the scope of every module that uses them.
`ifndef GO_TO_POINT_HEADING_CONTROLLER_CORE_ASSERT_SVH
`define GO_TO_POINT_HEADING_CONTROLLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset only.
`define GTP_ASSERT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset only.
`define GTP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GTP_ASSERT(name, ante, cons, msg)
`define GTP_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== sv/gtp_pkg.sv =====
// Package for the go-to-point controller: widths, constants, types, arctangent table.
// No dependencies; every other RTL file imports it.
`timescale 1ns / 1ps

package gtp_pkg;

    // Number of CORDIC micro-rotations (8 to 24).
    localparam int CORDIC_STEPS = 16;
    localparam int CNT_W        = $clog2(CORDIC_STEPS);

    // Arctangent table length and index width.
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = $clog2(ATAN_LEN);

    // Datapath widths.
    localparam int DXY_W  = 16;  // target minus pose, signed
    localparam int XY_W   = 27;  // CORDIC x and y, signed
    localparam int Z_W    = 26;  // CORDIC angle, 1/2^24 turn, signed
    localparam int DIST_W = 17;  // distance after gain correction
    localparam int ANG_W  = 16;  // binary angle

    // Shared multiplier.
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Fixed-point constants.
    localparam logic [Z_W-1:0]     QUARTER_TURN_Z = Z_W'(4194304);
    localparam logic [MUL_B_W-1:0] INV_GAIN_Q16   = MUL_B_W'(39797);
    localparam logic [MUL_B_W-1:0] PI_Q13         = MUL_B_W'(25736);
    localparam logic [ANG_W-1:0]   ROT_TOL_BAM    = ANG_W'(105);
    localparam logic [ANG_W-1:0]   HEAD_TOL_BAM   = ANG_W'(208);
    localparam logic [MUL_P_W:0]   DIST_ROUND     = (MUL_P_W + 1)'(1 << 23);
    localparam logic [Z_W-1:0]     BEAR_ROUND     = Z_W'(128);

    // Configuration register indexes.
    localparam logic [2:0] CFG_TARGET_X       = 3'd0;
    localparam logic [2:0] CFG_TARGET_Y       = 3'd1;
    localparam logic [2:0] CFG_K_ROTATE       = 3'd2;
    localparam logic [2:0] CFG_K_HEADING      = 3'd3;
    localparam logic [2:0] CFG_K_DISTANCE     = 3'd4;
    localparam logic [2:0] CFG_LINEAR_LIMIT   = 3'd5;
    localparam logic [2:0] CFG_ANGULAR_LIMIT  = 3'd6;
    localparam logic [2:0] CFG_DIST_TOLERANCE = 3'd7;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ROTATE  = 2'd1,
        PH_DRIVE   = 2'd2,
        PH_ARRIVED = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_CORDIC,
        S_DMUL,
        S_DIST,
        S_ROT,
        S_SMUL,
        S_SPD,
        S_TM1,
        S_TM2,
        S_TM3,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_stat;

    // atan(2^-i) in units of 1/2^24 turn.
    function automatic logic [Z_W-1:0] atan_z(input logic [ATAN_IDX_W-1:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(2097152);
            5'd1:    v = Z_W'(1238021);
            5'd2:    v = Z_W'(654136);
            5'd3:    v = Z_W'(332050);
            5'd4:    v = Z_W'(166669);
            5'd5:    v = Z_W'(83416);
            5'd6:    v = Z_W'(41718);
            5'd7:    v = Z_W'(20860);
            5'd8:    v = Z_W'(10430);
            5'd9:    v = Z_W'(5215);
            5'd10:   v = Z_W'(2608);
            5'd11:   v = Z_W'(1304);
            5'd12:   v = Z_W'(652);
            5'd13:   v = Z_W'(326);
            5'd14:   v = Z_W'(163);
            5'd15:   v = Z_W'(81);
            5'd16:   v = Z_W'(41);
            5'd17:   v = Z_W'(20);
            5'd18:   v = Z_W'(10);
            5'd19:   v = Z_W'(5);
            5'd20:   v = Z_W'(3);
            5'd21:   v = Z_W'(1);
            5'd22:   v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/gtp_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on gtp_pkg for the operand widths.
`timescale 1ns / 1ps

module gtp_mul import gtp_pkg::*; (
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_p
);

    logic [MUL_P_W-1:0] r_p;
    logic [MUL_P_W-1:0] n_p;

    assign n_p = MUL_P_W'(i_a) * MUL_P_W'(i_b);

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

// ===== sv/gtp_cordic.sv =====
// Iterative CORDIC vectoring unit: one shift-add micro-rotation per cycle.
// Depends on gtp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "go_to_point_heading_controller_core_assert.svh"

module gtp_cordic import gtp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DXY_W-1:0] i_dx,
    input  logic signed [DXY_W-1:0] i_dy,
    output logic signed [XY_W-1:0]  o_x,
    output logic signed [Z_W-1:0]   o_z,
    output t_cordic_stat            o_stat
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

    logic signed [XY_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [Z_W-1:0]  r_z, n_z;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_busy, n_busy, r_done, n_done;

    logic signed [XY_W-1:0] x_in, y_in, xs, ys;
    logic [Z_W-1:0]         atan_v;

    // Inputs scaled by 256.
    assign x_in   = {{(XY_W - DXY_W - 8){i_dx[DXY_W-1]}}, i_dx, 8'b0};
    assign y_in   = {{(XY_W - DXY_W - 8){i_dy[DXY_W-1]}}, i_dy, 8'b0};
    assign xs     = r_x >>> r_cnt;
    assign ys     = r_y >>> r_cnt;
    assign atan_v = atan_z(ATAN_IDX_W'(r_cnt));

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_cnt  = '0;
            n_busy = 1'b1;
            // Left half plane: rotate by a quarter turn first.
            if (x_in[XY_W-1]) begin
                if (!y_in[XY_W-1]) begin
                    n_x = y_in;
                    n_y = -x_in;
                    n_z = QUARTER_TURN_Z;
                end else begin
                    n_x = -y_in;
                    n_y = x_in;
                    n_z = -QUARTER_TURN_Z;
                end
            end else begin
                n_x = x_in;
                n_y = y_in;
                n_z = '0;
            end
        end else if (r_busy) begin
            if (!r_y[XY_W-1]) begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + atan_v;
            end else begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - atan_v;
            end
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x         = r_x;
    assign o_z         = r_z;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    `GTP_ASSERT(a_start_when_free, i_start, !r_busy, "CORDIC started while busy")
    `GTP_ASSERT(a_done_not_busy, r_done, !r_busy, "CORDIC done while still busy")
    `GTP_ASSERT_NEXT(a_last_step_done, r_busy && (r_cnt == CNT_LAST), r_done,
        "CORDIC did not finish after its last step")

endmodule

// ===== sv/go_to_point_heading_controller_core.sv =====
// Top level of the go-to-point controller: sequencer, configuration and result register.
// Depends on gtp_pkg, gtp_cordic, gtp_mul and the assertion macro header.
`timescale 1ns / 1ps
`include "go_to_point_heading_controller_core_assert.svh"

// The block takes one pose sample per transfer and answers each with one
// velocity command. It works on one sample at a time: o_in_stall is high from
// the cycle after a transfer until the result is written into the output
// register. A start sample or a sample in the drive phase runs the CORDIC
// vectoring unit, unless the pose is on the target, and waits for it to finish.
// It then uses the one shared multiplier up to four times. A sample in the
// rotate phase skips CORDIC, and a sample while idle or arrived goes from the
// load state straight to the final state.
// The output register lets the next sample enter while a result still waits;
// the sequencer only holds in its final state when that register is full.
// Configuration is a plain write port and is meant to be written while idle.
module go_to_point_heading_controller_core import gtp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration writes.
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    // Pose samples.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic [14:0]        i_pose_x,
    input  logic [14:0]        i_pose_y,
    input  logic signed [15:0] i_pose_heading,
    // Velocity commands.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [14:0]        o_linear_velocity,
    output logic signed [15:0] o_angular_velocity,
    output logic [1:0]         o_phase,
    output logic               o_arrived
);

    // Configuration registers.
    logic [14:0] r_target_x, r_target_y, r_lin_limit, r_ang_limit, r_dist_tol;
    logic [7:0]  r_k_rotate, r_k_heading, r_k_distance;

    // Sequencer and move state.
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [ANG_W-1:0]    r_goal, n_goal;

    // Per-sample working registers.
    logic                r_mode, n_mode;
    logic [14:0]         r_px, n_px, r_py, n_py;
    logic [ANG_W-1:0]    r_ph, n_ph;
    logic                r_zero, n_zero;
    logic [DIST_W-1:0]   r_dist, n_dist;
    logic [ANG_W-1:0]    r_err, n_err;
    logic [7:0]          r_k, n_k;
    logic [14:0]         r_lin, n_lin;
    logic [15:0]         r_ang, n_ang;
    logic                r_done, n_done;

    // Output register.
    logic                r_out_valid, n_out_valid;
    logic [14:0]         r_out_lin, n_out_lin;
    logic [15:0]         r_out_ang, n_out_ang;
    t_phase              r_out_phase, n_out_phase;
    logic                r_out_arrived, n_out_arrived;

    // Datapath wires.
    logic signed [DXY_W-1:0] dx, dy;
    logic                    pos_zero;
    logic                    cordic_start;
    logic signed [XY_W-1:0]  cordic_x;
    logic signed [Z_W-1:0]   cordic_z;
    t_cordic_stat            cordic_stat;
    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [MUL_P_W-1:0]      mul_p;
    logic [MUL_A_W-1:0]      x_pos;
    logic [MUL_P_W:0]        dist_sum;
    logic [DIST_W-1:0]       dist_calc;
    logic [Z_W-1:0]          bear_sum;
    logic [ANG_W-1:0]        bear_calc;
    logic [ANG_W-1:0]        rot_err, rot_abs, err_abs;
    logic [24:0]             spd_sum;
    logic [20:0]             spd_raw;
    logic [38:0]             turn_sum;
    logic [17:0]             turn_raw;
    logic [14:0]             turn_clamp;

    assign dx       = DXY_W'({1'b0, r_target_x}) - DXY_W'({1'b0, r_px});
    assign dy       = DXY_W'({1'b0, r_target_y}) - DXY_W'({1'b0, r_py});
    assign pos_zero = (dx == '0) && (dy == '0);

    gtp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_dx    (dx),
        .i_dy    (dy),
        .o_x     (cordic_x),
        .o_z     (cordic_z),
        .o_stat  (cordic_stat)
    );

    gtp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Distance is x times the inverse CORDIC gain, rounded half up. The bearing
    // is the accumulated angle rounded half up to a 16-bit binary angle.
    assign x_pos     = cordic_x[XY_W-1] ? '0 : cordic_x[MUL_A_W-1:0];
    assign dist_sum  = {1'b0, mul_p} + DIST_ROUND;
    assign dist_calc = dist_sum[DIST_W+23:24];
    assign bear_sum  = cordic_z + BEAR_ROUND;
    assign bear_calc = bear_sum[23:8];

    // Heading errors wrap naturally in 16-bit binary angle.
    assign rot_err = r_goal - r_ph;
    assign rot_abs = rot_err[ANG_W-1] ? -rot_err : rot_err;
    assign err_abs = r_err[ANG_W-1] ? -r_err : r_err;

    // Forward speed: (k_distance * distance + 8) >> 4.
    assign spd_sum = mul_p[24:0] + 25'd8;
    assign spd_raw = spd_sum[24:4];

    // Turn rate magnitude: (k * |e| * 25736 + 2^20) >> 21, then clamped.
    assign turn_sum   = mul_p[38:0] + 39'(1 << 20);
    assign turn_raw   = turn_sum[38:21];
    assign turn_clamp = (turn_raw > {3'b0, r_ang_limit}) ? r_ang_limit : turn_raw[14:0];

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_goal        = r_goal;
        n_mode        = r_mode;
        n_px          = r_px;
        n_py          = r_py;
        n_ph          = r_ph;
        n_zero        = r_zero;
        n_dist        = r_dist;
        n_err         = r_err;
        n_k           = r_k;
        n_lin         = r_lin;
        n_ang         = r_ang;
        n_done        = r_done;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_lin     = r_out_lin;
        n_out_ang     = r_out_ang;
        n_out_phase   = r_out_phase;
        n_out_arrived = r_out_arrived;
        cordic_start  = 1'b0;
        mul_a         = '0;
        mul_b         = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_px    = i_pose_x;
                    n_py    = i_pose_y;
                    n_ph    = i_pose_heading;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_lin  = '0;
                n_ang  = '0;
                n_done = 1'b0;
                if (r_mode || (r_phase == PH_DRIVE)) begin
                    // Pose on the target: bearing and distance are both zero.
                    n_zero       = pos_zero;
                    cordic_start = !pos_zero;
                    n_state      = S_CORDIC;
                end else if (r_phase == PH_ROTATE) begin
                    n_state = S_ROT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CORDIC: begin
                if (r_zero || cordic_stat.done) begin
                    n_state = S_DMUL;
                end
            end
            S_DMUL: begin
                mul_a   = x_pos;
                mul_b   = INV_GAIN_Q16;
                n_state = S_DIST;
            end
            S_DIST: begin
                n_dist = r_zero ? '0 : dist_calc;
                if (r_mode) begin
                    // A start latches the bearing and is then handled as a
                    // rotate-phase sample of the same pose.
                    n_goal  = r_zero ? '0 : bear_calc;
                    n_phase = PH_ROTATE;
                    n_state = S_ROT;
                end else if ((r_zero ? '0 : dist_calc) < {2'b0, r_dist_tol}) begin
                    n_phase = PH_ARRIVED;
                    n_done  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_err   = (r_zero ? '0 : bear_calc) - r_ph;
                    n_state = S_SMUL;
                end
            end
            S_ROT: begin
                if (rot_abs < ROT_TOL_BAM) begin
                    n_phase = PH_DRIVE;
                    n_state = S_DONE;
                end else begin
                    n_err   = rot_err;
                    n_k     = r_k_rotate;
                    n_state = S_TM1;
                end
            end
            S_SMUL: begin
                mul_a   = MUL_A_W'(r_dist);
                mul_b   = MUL_B_W'(r_k_distance);
                n_state = S_SPD;
            end
            S_SPD: begin
                if (err_abs > HEAD_TOL_BAM) begin
                    n_lin = '0;
                end else if (spd_raw > {6'b0, r_lin_limit}) begin
                    n_lin = r_lin_limit;
                end else begin
                    n_lin = spd_raw[14:0];
                end
                n_k     = r_k_heading;
                n_state = S_TM1;
            end
            S_TM1: begin
                mul_a   = MUL_A_W'(err_abs);
                mul_b   = MUL_B_W'(r_k);
                n_state = S_TM2;
            end
            S_TM2: begin
                mul_a   = MUL_A_W'(mul_p[23:0]);
                mul_b   = PI_Q13;
                n_state = S_TM3;
            end
            S_TM3: begin
                n_ang   = r_err[ANG_W-1] ? -{1'b0, turn_clamp} : {1'b0, turn_clamp};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_lin     = r_lin;
                    n_out_ang     = r_ang;
                    n_out_phase   = r_phase;
                    n_out_arrived = r_done;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_goal      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_goal      <= n_goal;
            r_out_valid <= n_out_valid;
        end
        r_mode        <= n_mode;
        r_px          <= n_px;
        r_py          <= n_py;
        r_ph          <= n_ph;
        r_zero        <= n_zero;
        r_dist        <= n_dist;
        r_err         <= n_err;
        r_k           <= n_k;
        r_lin         <= n_lin;
        r_ang         <= n_ang;
        r_done        <= n_done;
        r_out_lin     <= n_out_lin;
        r_out_ang     <= n_out_ang;
        r_out_phase   <= n_out_phase;
        r_out_arrived <= n_out_arrived;
    end

    // Configuration registers; values are masked to each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x   <= 15'd0;
            r_target_y   <= 15'd0;
            r_k_rotate   <= 8'd96;
            r_k_heading  <= 8'd128;
            r_k_distance <= 8'd32;
            r_lin_limit  <= 15'd4096;
            r_ang_limit  <= 15'd7168;
            r_dist_tol   <= 15'd20;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_X:       r_target_x   <= i_cfg_data;
                CFG_TARGET_Y:       r_target_y   <= i_cfg_data;
                CFG_K_ROTATE:       r_k_rotate   <= i_cfg_data[7:0];
                CFG_K_HEADING:      r_k_heading  <= i_cfg_data[7:0];
                CFG_K_DISTANCE:     r_k_distance <= i_cfg_data[7:0];
                CFG_LINEAR_LIMIT:   r_lin_limit  <= i_cfg_data;
                CFG_ANGULAR_LIMIT:  r_ang_limit  <= i_cfg_data;
                CFG_DIST_TOLERANCE: r_dist_tol   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_linear_velocity  = r_out_lin;
    assign o_angular_velocity = r_out_ang;
    assign o_phase            = r_out_phase;
    assign o_arrived          = r_out_arrived;

    `GTP_ASSERT(a_arrive_stops, r_out_valid && r_out_arrived,
        (r_out_phase == PH_ARRIVED) && (r_out_lin == '0) && (r_out_ang == '0),
        "arrival result must report arrived phase and zero velocities")
    `GTP_ASSERT(a_speed_only_driving, r_out_valid && (r_out_phase != PH_DRIVE),
        r_out_lin == '0, "forward speed outside the drive phase")
    `GTP_ASSERT(a_arrive_from_drive,
        (n_phase == PH_ARRIVED) && (r_phase != PH_ARRIVED),
        (r_phase == PH_DRIVE) && !r_mode, "arrival reached from outside the drive phase")

endmodule

// ===== sim/go_to_point_heading_controller_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the go-to-point heading controller core.
// Depends on gtp_pkg and the RTL top level, which also needs gtp_cordic and gtp_mul.

module go_to_point_heading_controller_core_test;
    import gtp_pkg::*;

    // One pose transfer into the block.
    typedef struct packed {
        logic        mode;
        logic [14:0] x;
        logic [14:0] y;
        logic [15:0] hd;
    } pose_t;

    // One velocity command out of the block.
    typedef struct packed {
        logic [14:0] lin;
        logic [15:0] ang;
        t_phase      phase;
        logic        arrived;
    } cmd_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [14:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_mode = 1'b0;
    logic [14:0]        i_pose_x = '0;
    logic [14:0]        i_pose_y = '0;
    logic signed [15:0] i_pose_heading = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [14:0]        o_linear_velocity;
    logic signed [15:0] o_angular_velocity;
    logic [1:0]         o_phase;
    logic               o_arrived;

    // Arctangent of 2^-i in units of 1/2^24 turn, for the bearing/distance predictor.
    longint atan_turn [0:23] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81,
        41, 20, 10, 5, 3, 1, 1, 0
    };

    // Predictor copy of the configuration and of the move state.
    int unsigned cfg_reg [8];
    t_phase      move_phase = PH_IDLE;
    logic [15:0] goal_heading = '0;

    pose_t pose_q [$];   // poses waiting to be sent
    cmd_t  cmd_q [$];    // commands predicted and not yet seen
    int    fail_cnt = 0;
    int    planned = 0;

    // Handshake bookkeeping shared between the monitor and the two drivers.
    bit in_taken = 1'b0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    int send_gap = 0, send_span = 0;
    bit send_lazy = 1'b0;
    int stall_left = 0, recv_span = 0, hold_left = 0;
    bit recv_lazy = 1'b0;

    go_to_point_heading_controller_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_mode             (i_mode),
        .i_pose_x           (i_pose_x),
        .i_pose_y           (i_pose_y),
        .i_pose_heading     (i_pose_heading),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_linear_velocity  (o_linear_velocity),
        .o_angular_velocity (o_angular_velocity),
        .o_phase            (o_phase),
        .o_arrived          (o_arrived)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // CORDIC vectoring on the offset to the target. The offset is scaled by 256,
    // the left half plane is folded by a quarter turn first, and every shift
    // rounds toward minus infinity. Distance comes back in Q5.11 after the gain
    // correction, bearing as a 16-bit binary angle.
    function automatic void vector_to(input int dx, input int dy,
                                      output longint range_q11, output logic [15:0] brg);
        longint x, y, z, xs, ys, t;
        x = longint'(dx) * 256;
        y = longint'(dy) * 256;
        z = 0;
        range_q11 = 0;
        brg = '0;
        if (dx == 0 && dy == 0) begin
            return;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = longint'(QUARTER_TURN_Z);
            end else begin
                x = -y;
                y = t;
                z = -longint'(QUARTER_TURN_Z);
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += atan_turn[i];
            end else begin
                x -= ys;
                y += xs;
                z -= atan_turn[i];
            end
        end
        if (x < 0) begin
            x = 0;
        end
        range_q11 = (x * longint'(INV_GAIN_Q16) + (longint'(1) << 23)) >>> 24;
        t = (z + 128) >>> 8;
        brg = t[15:0];
    endfunction

    // Heading error wrapped into one signed turn.
    function automatic int heading_err(input logic [15:0] want, input logic [15:0] have);
        logic signed [15:0] d;
        d = want - have;
        return int'(d);
    endfunction

    // Turn rate k * e * pi / 256: the magnitude is rounded half away from zero,
    // clamped to the angular limit, and then the sign of the error is put back.
    function automatic logic [15:0] rate_cmd(input int unsigned k, input int e);
        longint m, r;
        m = longint'(e < 0 ? -e : e) * longint'(k);
        r = (m * longint'(PI_Q13) + (longint'(1) << 20)) >>> 21;
        if (r > longint'(cfg_reg[CFG_ANGULAR_LIMIT])) begin
            r = longint'(cfg_reg[CFG_ANGULAR_LIMIT]);
        end
        if (e < 0) begin
            r = -r;
        end
        return r[15:0];
    endfunction

    // Advances the predicted controller by one accepted pose and returns the
    // command that the block must answer with.
    task automatic advance_controller(input pose_t p, output cmd_t c);
        int          dx, dy, e;
        longint      range_q11, spd;
        logic [15:0] brg;
        dx = int'(cfg_reg[CFG_TARGET_X]) - int'(p.x);
        dy = int'(cfg_reg[CFG_TARGET_Y]) - int'(p.y);
        c = '0;
        // A start latches the bearing and falls through as a rotate sample.
        if (p.mode) begin
            vector_to(dx, dy, range_q11, brg);
            goal_heading = brg;
            move_phase = PH_ROTATE;
        end
        if (move_phase == PH_ROTATE) begin
            e = heading_err(goal_heading, p.hd);
            if (e < int'(ROT_TOL_BAM) && e > -int'(ROT_TOL_BAM)) begin
                move_phase = PH_DRIVE;
            end else begin
                c.ang = rate_cmd(cfg_reg[CFG_K_ROTATE], e);
            end
        end else if (move_phase == PH_DRIVE) begin
            vector_to(dx, dy, range_q11, brg);
            if (range_q11 < longint'(cfg_reg[CFG_DIST_TOLERANCE])) begin
                move_phase = PH_ARRIVED;
                c.arrived = 1'b1;
            end else begin
                e = heading_err(brg, p.hd);
                spd = (range_q11 * longint'(cfg_reg[CFG_K_DISTANCE]) + 8) >>> 4;
                if (spd > longint'(cfg_reg[CFG_LINEAR_LIMIT])) begin
                    spd = longint'(cfg_reg[CFG_LINEAR_LIMIT]);
                end
                // No forward motion while the robot points too far off.
                if (e > int'(HEAD_TOL_BAM) || e < -int'(HEAD_TOL_BAM)) begin
                    spd = 0;
                end
                c.lin = spd[14:0];
                c.ang = rate_cmd(cfg_reg[CFG_K_HEADING], e);
            end
        end
        c.phase = move_phase;
    endtask

    task automatic flag_field(input string what, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // Monitor: at each rising edge, check a command transfer against the oldest
    // prediction, track configuration writes, and predict for a pose transfer.
    // The check comes first so a command and a pose in the same cycle keep order.
    always @(posedge i_clk) begin
        cmd_t  want;
        pose_t taken;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (cmd_q.size() == 0) begin
                    $display("%0t: command with none expected, actual lin %0d ang %0d phase %0d",
                             $time, o_linear_velocity, o_angular_velocity, o_phase);
                    fail_cnt++;
                end else begin
                    want = cmd_q.pop_front();
                    flag_field("linear_velocity", int'(want.lin), int'(o_linear_velocity));
                    flag_field("angular_velocity", int'($signed(want.ang)),
                               int'(o_angular_velocity));
                    flag_field("phase", int'(want.phase), int'(o_phase));
                    flag_field("arrived", int'(want.arrived), int'(o_arrived));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_K_ROTATE, CFG_K_HEADING, CFG_K_DISTANCE: begin
                        cfg_reg[i_cfg_index] = i_cfg_data[7:0];
                    end
                    default: begin
                        cfg_reg[i_cfg_index] = i_cfg_data;
                    end
                endcase
            end
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) begin
                taken = '{mode: i_mode, x: i_pose_x, y: i_pose_y, hd: i_pose_heading};
                advance_controller(taken, want);
                cmd_q.push_back(want);
            end
        end
    end

    // Pose driver: a stalled transfer is held as it is; otherwise the next pose
    // goes out unless a random gap is running. Gaps come in bursts during lazy
    // stretches and never in the calm closing part.
    always @(negedge i_clk) begin
        pose_t nxt;
        bit    go;
        if (send_span == 0) begin
            send_span = $urandom_range(20, 80);
            send_lazy = $urandom_range(0, 1);
        end else begin
            send_span--;
        end
        if (!(i_in_valid && !in_taken)) begin
            go = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pose_q.size() > 0) begin
                if (!calm && send_lazy && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(0, 10);
                end else begin
                    nxt = pose_q.pop_front();
                    go = 1'b1;
                end
            end
            i_in_valid <= go;
            if (go) begin
                i_mode <= nxt.mode;
                i_pose_x <= nxt.x;
                i_pose_y <= nxt.y;
                i_pose_heading <= nxt.hd;
            end
        end
    end

    // Command receiver: random stall bursts, plus one long hold-off on request
    // that lets the block fill up and stall the pose side.
    always @(negedge i_clk) begin
        bit stall_now;
        if (recv_span == 0) begin
            recv_span = $urandom_range(20, 80);
            recv_lazy = $urandom_range(0, 1);
        end else begin
            recv_span--;
        end
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            stall_now = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            stall_now = 1'b1;
        end else if (!calm && recv_lazy && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 10);
            stall_now = 1'b1;
        end else begin
            stall_now = 1'b0;
        end
        i_out_stall <= stall_now;
    end

    function automatic int clamp15(input int v);
        return v < 0 ? 0 : (v > 32767 ? 32767 : v);
    endfunction

    task automatic push_pose(input bit mode, input int x, input int y, input logic [15:0] hd);
        pose_t p;
        p = '{mode: mode, x: 15'(x), y: 15'(y), hd: hd};
        pose_q.push_back(p);
        planned++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input int data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 15'(data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Gains are 8 bits wide; the upper data bits are filled with noise that the
    // block must drop.
    task automatic set_config(input int tx, input int ty, input int kr, input int kh,
                              input int kd, input int lim_l, input int lim_a, input int tol);
        write_reg(CFG_TARGET_X, tx);
        write_reg(CFG_TARGET_Y, ty);
        write_reg(CFG_K_ROTATE, int'({7'($urandom), 8'(kr)}));
        write_reg(CFG_K_HEADING, int'({7'($urandom), 8'(kh)}));
        write_reg(CFG_K_DISTANCE, int'({7'($urandom), 8'(kd)}));
        write_reg(CFG_LINEAR_LIMIT, lim_l);
        write_reg(CFG_ANGULAR_LIMIT, lim_a);
        write_reg(CFG_DIST_TOLERANCE, tol);
    endtask

    // Lets every queued pose go out and every command come back, then leaves
    // room for the block to settle before the next register write.
    task automatic wait_drain();
        while (pose_q.size() > 0 || i_in_valid || cmd_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
    endtask

    // A well-formed move: start, turn toward the goal, align, then drive along
    // the line to the target while steering with small heading noise. One move
    // in eight breaks off before arriving, so the next start restarts it.
    task automatic plan_move(input int n_rot, input int n_drv);
        int          tx, ty, sx, sy, px, py, e0, j, last;
        longint      range_q11;
        logic [15:0] brg, hd;
        tx = int'(cfg_reg[CFG_TARGET_X]);
        ty = int'(cfg_reg[CFG_TARGET_Y]);
        if ($urandom_range(0, 9) < 7) begin
            sx = $urandom_range(0, 32767);
            sy = $urandom_range(0, 32767);
        end else begin
            sx = clamp15(tx + int'($urandom_range(0, 4000)) - 2000);
            sy = clamp15(ty + int'($urandom_range(0, 4000)) - 2000);
        end
        hd = 16'($urandom);
        push_pose(1'b1, sx, sy, hd);
        vector_to(tx - sx, ty - sy, range_q11, brg);
        e0 = heading_err(brg, hd);
        for (int k = 1; k <= n_rot; k++) begin
            push_pose(1'b0, sx, sy, brg - 16'(e0 * (n_rot + 1 - k) / (n_rot + 1)));
        end
        push_pose(1'b0, sx, sy, brg + 16'(int'($urandom_range(0, 208)) - 104));
        last = ($urandom_range(0, 7) == 0) ? n_drv - 1 : n_drv;
        for (int k = 1; k <= last; k++) begin
            j = (k == n_drv) ? 0 : int'($urandom_range(0, 60)) - 30;
            px = clamp15(sx + (tx - sx) * k / n_drv + j);
            py = clamp15(sy + (ty - sy) * k / n_drv - j);
            vector_to(tx - px, ty - py, range_q11, brg);
            j = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 4000)) - 2000
                                            : int'($urandom_range(0, 400)) - 200;
            push_pose(1'b0, px, py, brg + 16'(j));
        end
        // Up to two random samples after the drive; after an arrival the block answers them with zeros.
        repeat ($urandom_range(0, 2)) begin
            push_pose(1'b0, $urandom_range(0, 32767), $urandom_range(0, 32767), 16'($urandom));
        end
    endtask

    // Mostly moves; the rest is unstructured noise with the odd stray start.
    task automatic plan_traffic(input int count);
        int stop_at;
        stop_at = planned + count;
        while (planned < stop_at) begin
            if ($urandom_range(0, 9) < 8) begin
                plan_move($urandom_range(0, 4), $urandom_range(1, 8));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    push_pose($urandom_range(0, 5) == 0, $urandom_range(0, 32767),
                              $urandom_range(0, 32767), 16'($urandom));
                end
            end
        end
    endtask

    initial begin
        longint      range_q11;
        logic [15:0] brg;
        cfg_reg[CFG_TARGET_X] = 0;
        cfg_reg[CFG_TARGET_Y] = 0;
        cfg_reg[CFG_K_ROTATE] = 96;
        cfg_reg[CFG_K_HEADING] = 128;
        cfg_reg[CFG_K_DISTANCE] = 32;
        cfg_reg[CFG_LINEAR_LIMIT] = 4096;
        cfg_reg[CFG_ANGULAR_LIMIT] = 7168;
        cfg_reg[CFG_DIST_TOLERANCE] = 20;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with the reset configuration (target at the origin).
        // Samples while idle, at both corners of the field.
        push_pose(1'b0, 0, 0, 16'h0000);
        push_pose(1'b0, 32767, 32767, 16'h8000);
        // Start on the target itself: zero bearing, already aligned, so the
        // rotation is done at once; then a drive sample there arrives.
        push_pose(1'b1, 0, 0, 16'h0000);
        push_pose(1'b0, 0, 0, 16'h0000);
        push_pose(1'b0, 100, 100, 16'h1234);
        // Restart from the far corner after arrival, then walk the heading
        // across the rotate tolerance: half a turn off, just outside, inside.
        vector_to(-32767, -32767, range_q11, brg);
        push_pose(1'b1, 32767, 32767, 16'h7FFF);
        push_pose(1'b0, 32767, 32767, brg + 16'd32768);
        push_pose(1'b0, 32767, 32767, brg - 16'd105);
        push_pose(1'b0, 32767, 32767, brg + 16'd105);
        push_pose(1'b0, 32767, 32767, brg + 16'd104);
        // Drive: just past the heading tolerance stops forward motion, just
        // inside lets the clamped speed through; then a pose inside tolerance.
        push_pose(1'b0, 32767, 32767, brg + 16'd209);
        push_pose(1'b0, 32767, 32767, brg - 16'd208);
        push_pose(1'b0, 16, 0, 16'h0000);
        // Straight down and straight left of the target, with a restart in
        // the middle of the rotation, then a restart in the middle of a drive.
        push_pose(1'b1, 0, 32767, 16'h0000);
        push_pose(1'b1, 32767, 0, 16'h8000);
        push_pose(1'b0, 32767, 0, 16'h8000);
        push_pose(1'b1, 0, 0, 16'h4000);
        push_pose(1'b0, 0, 0, 16'h4000);
        wait_drain();

        // Nominal gains with a target mid-field. The receiver holds off for a
        // long stretch while poses keep coming, then the sender pauses until
        // every command is back before it goes on.
        set_config(12000, 9000, 96, 128, 32, 4096, 7168, 40);
        plan_traffic(130);
        @(posedge i_clk);
        hold_req = 1'b1;
        wait_drain();
        plan_traffic(120);
        wait_drain();

        // Upper extremes: full gains and limits, target in a corner, and a
        // zero tolerance so a drive never ends.
        set_config(32767, 0, 255, 255, 255, 32767, 32767, 0);
        plan_traffic(120);
        wait_drain();

        // Lower extremes: zero gains and limits, the widest tolerance.
        set_config(0, 32767, 0, 0, 0, 0, 0, 32767);
        plan_traffic(60);
        wait_drain();

        set_config($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 32767),
                   $urandom_range(0, 32767), $urandom_range(0, 200));
        plan_traffic(170);
        wait_drain();

        // Closing part at full rate on both sides.
        @(posedge i_clk);
        calm = 1'b1;
        set_config($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(1024, 32767),
                   $urandom_range(1024, 32767), $urandom_range(10, 100));
        plan_traffic(100);
        wait_drain();

        if (fail_cnt == 0 && cmd_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog, several times the slowest correct run.
    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/gtp_pkg.sv
sv/gtp_mul.sv
sv/gtp_cordic.sv
sv/go_to_point_heading_controller_core.sv
sim/go_to_point_heading_controller_core_test.sv
